FILE: rtl/core/sbtr_pkg.sv
// shared types, constants and glyph rom for the scaled bitmap text renderer
`timescale 1ns / 1ps

package sbtr_pkg;

    localparam int unsigned PANEL_WIDTH_DEF  = 128;
    localparam int unsigned PANEL_HEIGHT_DEF = 160;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned RECT_W  = 10;
    localparam int unsigned SCALE_W = 8;
    localparam int unsigned COLOR_W = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned GLYPH_W = 15;
    localparam int unsigned PIX_W   = 4;
    localparam int unsigned COL_W   = 2;

    localparam logic [PIX_W-1:0]  LAST_PIX = PIX_W'(GLYPH_W - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(2);
    localparam logic [CODE_W-1:0] CODE_NUL = '0;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } sbtr_state_t;

    // rows top to bottom, one octal digit per row, msb of a digit is the left column
    function automatic logic [GLYPH_W-1:0] glyph_rom(input logic [CODE_W-1:0] code_in);
        logic [CODE_W-1:0]  code;
        logic [GLYPH_W-1:0] bits;
        code = code_in;
        if (code >= 8'h61 && code <= 8'h7A) begin
            code = code - 8'h20;
        end
        case (code)
            8'h30: bits = 15'o75557;  8'h31: bits = 15'o26227;
            8'h32: bits = 15'o71747;  8'h33: bits = 15'o71717;
            8'h34: bits = 15'o55711;  8'h35: bits = 15'o74717;
            8'h36: bits = 15'o74757;  8'h37: bits = 15'o71122;
            8'h38: bits = 15'o75757;  8'h39: bits = 15'o75717;
            8'h41: bits = 15'o25755;  8'h42: bits = 15'o65656;
            8'h43: bits = 15'o34443;  8'h44: bits = 15'o65556;
            8'h45: bits = 15'o74647;  8'h46: bits = 15'o74644;
            8'h47: bits = 15'o34553;  8'h48: bits = 15'o55755;
            8'h49: bits = 15'o72227;  8'h4A: bits = 15'o11152;
            8'h4B: bits = 15'o55655;  8'h4C: bits = 15'o44447;
            8'h4D: bits = 15'o57755;  8'h4E: bits = 15'o57775;
            8'h4F: bits = 15'o25552;  8'h50: bits = 15'o65644;
            8'h51: bits = 15'o25531;  8'h52: bits = 15'o65655;
            8'h53: bits = 15'o34216;  8'h54: bits = 15'o72222;
            8'h55: bits = 15'o55557;  8'h56: bits = 15'o55552;
            8'h57: bits = 15'o55775;  8'h58: bits = 15'o55255;
            8'h59: bits = 15'o55222;  8'h5A: bits = 15'o71247;
            8'h2D: bits = 15'o00700;  8'h3A: bits = 15'o02020;
            8'h2E: bits = 15'o00002;  8'h2F: bits = 15'o11244;
            8'h5F: bits = 15'o00007;  8'h3F: bits = 15'o61202;
            8'h2B: bits = 15'o02720;  8'h3D: bits = 15'o07070;
            8'h2A: bits = 15'o05250;  8'h21: bits = 15'o22202;
            8'h40: bits = 15'o75743;  8'h23: bits = 15'o57575;
            8'h24: bits = 15'o36236;  8'h25: bits = 15'o51245;
            8'h26: bits = 15'o25253;  8'h28: bits = 15'o12221;
            8'h29: bits = 15'o42224;  8'h5B: bits = 15'o32223;
            8'h5D: bits = 15'o62226;  8'h27: bits = 15'o22000;
            8'h2C: bits = 15'o00024;  8'h3B: bits = 15'o02024;
            8'h22: bits = 15'o55000;  8'h5C: bits = 15'o44211;
            8'h3C: bits = 15'o12421;  8'h3E: bits = 15'o42124;
            8'h5E: bits = 15'o25000;  8'h60: bits = 15'o21000;
            8'h7B: bits = 15'o12621;  8'h7D: bits = 15'o42324;
            8'h7C: bits = 15'o22222;  8'h7E: bits = 15'o03600;
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

FILE: rtl/core/scaled_bitmap_text_renderer.sv
// top level of the scaled bitmap text renderer: sequencer, coordinate stepper and output word
`timescale 1ns / 1ps

// first square word of a character: moved to the output register at its second on-panel
//   pixel, or by the flush step when the character has only one
// a character runs through an accept step, 15 glyph pixel steps through the shared stepper
//   and a flush step; no new character is taken until the sequencer is idle again
// an output stall can hold a glyph pixel step or the flush step of the character
// reset (aresetn low, synchronous): cursor, count and limit cleared, text closed,
//   sequencer idle, no word pending or on the output

module scaled_bitmap_text_renderer #(
    parameter int unsigned PANEL_WIDTH  = sbtr_pkg::PANEL_WIDTH_DEF,
    parameter int unsigned PANEL_HEIGHT = sbtr_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // character input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x[15:0], start_y[31:16], char_limit[39:32], char_code[47:40],
    // ink_color[63:48], scale[71:64]
    input  logic [sbtr_pkg::S_TDATA_W-1:0] s_tdata,
    // start_text[0]
    input  logic                           s_tuser,
    // square fill commands
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rect_x[9:0], rect_y[19:10], rect_size[27:20], rect_color[43:28], zero[47:44]
    output logic [sbtr_pkg::M_TDATA_W-1:0] m_tdata,
    // last square of the character
    output logic                           m_tlast
);

    localparam int unsigned SUM_W = sbtr_pkg::COORD_W + 1;
    localparam int unsigned LIM_W = 11;

    // unpacked input word
    logic                            in_start;
    logic [sbtr_pkg::COORD_W-1:0]    in_x;
    logic [sbtr_pkg::COORD_W-1:0]    in_y;
    logic [sbtr_pkg::COUNT_W-1:0]    in_max;
    logic [sbtr_pkg::CODE_W-1:0]     in_code;
    logic [sbtr_pkg::COLOR_W-1:0]    in_ink;
    logic [sbtr_pkg::SCALE_W-1:0]    in_scale;

    assign in_start = s_tuser;
    assign in_x     = s_tdata[15:0];
    assign in_y     = s_tdata[31:16];
    assign in_max   = s_tdata[39:32];
    assign in_code  = s_tdata[47:40];
    assign in_ink   = s_tdata[63:48];
    assign in_scale = s_tdata[71:64];

    // text state
    sbtr_pkg::sbtr_state_t           state_reg, state_next;
    logic [sbtr_pkg::COORD_W-1:0]    cursor_x_reg, cursor_x_next;
    logic [sbtr_pkg::COORD_W-1:0]    cursor_y_reg, cursor_y_next;
    logic [sbtr_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [sbtr_pkg::COUNT_W-1:0]    limit_reg, limit_next;
    logic                            ended_reg, ended_next;

    // per character working registers
    logic [sbtr_pkg::GLYPH_W-1:0]    glyph_reg, glyph_next;
    logic [sbtr_pkg::PIX_W-1:0]      pix_reg, pix_next;
    logic [sbtr_pkg::COL_W-1:0]      col_reg, col_next;
    logic [sbtr_pkg::COORD_W-1:0]    base_x_reg, base_x_next;
    logic [sbtr_pkg::COORD_W-1:0]    px_reg, px_next;
    logic [sbtr_pkg::COORD_W-1:0]    py_reg, py_next;
    logic [sbtr_pkg::SCALE_W-1:0]    scale_reg, scale_next;
    logic [sbtr_pkg::COLOR_W-1:0]    ink_reg, ink_next;

    // one square held back until we know whether another follows
    logic                            pend_valid_reg, pend_valid_next;
    logic [sbtr_pkg::RECT_W-1:0]     pend_x_reg, pend_x_next;
    logic [sbtr_pkg::RECT_W-1:0]     pend_y_reg, pend_y_next;

    // output word register
    logic                            out_valid_reg, out_valid_next;
    logic [sbtr_pkg::RECT_W-1:0]     out_x_reg, out_x_next;
    logic [sbtr_pkg::RECT_W-1:0]     out_y_reg, out_y_next;
    logic [sbtr_pkg::SCALE_W-1:0]    out_size_reg, out_size_next;
    logic [sbtr_pkg::COLOR_W-1:0]    out_color_reg, out_color_next;
    logic                            out_last_reg, out_last_next;

    // effective text state once a start in the accepted word is applied
    logic [sbtr_pkg::COORD_W-1:0]    eff_x;
    logic [sbtr_pkg::COORD_W-1:0]    eff_y;
    logic [sbtr_pkg::COUNT_W-1:0]    eff_count;
    logic [sbtr_pkg::COUNT_W-1:0]    eff_limit;
    logic                            eff_ended;

    logic                            accept;
    logic                            draw;
    logic                            out_free;
    logic [SUM_W-1:0]                x_end;
    logic [SUM_W-1:0]                y_end;
    logic                            hit;
    logic                            stall;

    assign s_tready = (state_reg == sbtr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign eff_x     = in_start ? in_x : cursor_x_reg;
    assign eff_y     = in_start ? in_y : cursor_y_reg;
    assign eff_count = in_start ? '0 : count_reg;
    assign eff_limit = in_start ? in_max : limit_reg;
    assign eff_ended = in_start ? 1'b0 : ended_reg;

    // a character is drawn only on open text, non-nul code and count below the limit
    assign draw = accept && !eff_ended && (in_code != sbtr_pkg::CODE_NUL)
                  && (eff_count < eff_limit);

    // edge test of the current glyph pixel, sums kept one bit wider than the cursor
    assign x_end = {1'b0, px_reg} + SUM_W'(scale_reg);
    assign y_end = {1'b0, py_reg} + SUM_W'(scale_reg);
    assign hit   = glyph_reg[sbtr_pkg::GLYPH_W-1] && (scale_reg != '0)
                   && (x_end <= SUM_W'(PANEL_WIDTH)) && (y_end <= SUM_W'(PANEL_HEIGHT));

    // a new square cannot enter while the held one has nowhere to go
    assign stall = hit && pend_valid_reg && !out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbtr_pkg::ST_IDLE: begin
                if (draw) begin
                    state_next = sbtr_pkg::ST_SCAN;
                end
            end
            sbtr_pkg::ST_SCAN: begin
                if (!stall && pix_reg == sbtr_pkg::LAST_PIX) begin
                    state_next = sbtr_pkg::ST_FLUSH;
                end
            end
            sbtr_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = sbtr_pkg::ST_IDLE;
                end
            end
            default: state_next = sbtr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        count_next      = count_reg;
        limit_next      = limit_reg;
        ended_next      = ended_reg;
        glyph_next      = glyph_reg;
        pix_next        = pix_reg;
        col_next        = col_reg;
        base_x_next     = base_x_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        scale_next      = scale_reg;
        ink_next        = ink_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_size_next   = out_size_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            sbtr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_start) begin
                        cursor_x_next = in_x;
                        cursor_y_next = in_y;
                        limit_next    = in_max;
                        count_next    = '0;
                        ended_next    = 1'b0;
                    end
                    if (!eff_ended && !draw) begin
                        // nul code or limit reached closes the text
                        ended_next = 1'b1;
                    end
                    if (draw) begin
                        cursor_x_next = eff_x + {6'd0, in_scale, 2'b00};
                        count_next    = eff_count + sbtr_pkg::COUNT_W'(1);
                        glyph_next    = sbtr_pkg::glyph_rom(in_code);
                        pix_next      = '0;
                        col_next      = '0;
                        base_x_next   = eff_x;
                        px_next       = eff_x;
                        py_next       = eff_y;
                        scale_next    = in_scale;
                        ink_next      = in_ink;
                    end
                end
            end
            sbtr_pkg::ST_SCAN: begin
                if (!stall) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_x_next     = pend_x_reg;
                            out_y_next     = pend_y_reg;
                            out_size_next  = scale_reg;
                            out_color_next = ink_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = px_reg[sbtr_pkg::RECT_W-1:0];
                        pend_y_next     = py_reg[sbtr_pkg::RECT_W-1:0];
                    end
                    // step to the next glyph pixel, row-major
                    glyph_next = {glyph_reg[sbtr_pkg::GLYPH_W-2:0], 1'b0};
                    pix_next   = pix_reg + sbtr_pkg::PIX_W'(1);
                    if (col_reg == sbtr_pkg::LAST_COL) begin
                        col_next = '0;
                        px_next  = base_x_reg;
                        py_next  = py_reg + sbtr_pkg::COORD_W'(scale_reg);
                    end else begin
                        col_next = col_reg + sbtr_pkg::COL_W'(1);
                        px_next  = px_reg + sbtr_pkg::COORD_W'(scale_reg);
                    end
                end
            end
            sbtr_pkg::ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    out_valid_next  = 1'b1;
                    out_x_next      = pend_x_reg;
                    out_y_next      = pend_y_reg;
                    out_size_next   = scale_reg;
                    out_color_next  = ink_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sbtr_pkg::ST_IDLE;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            count_reg      <= '0;
            limit_reg      <= '0;
            ended_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            count_reg      <= count_next;
            limit_reg      <= limit_next;
            ended_reg      <= ended_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        glyph_reg     <= glyph_next;
        pix_reg       <= pix_next;
        col_reg       <= col_next;
        base_x_reg    <= base_x_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        scale_reg     <= scale_next;
        ink_reg       <= ink_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_size_reg  <= out_size_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_color_reg, out_size_reg, out_y_reg, out_x_reg};

`ifndef SYNTHESIS
    // nothing may be held back once the sequencer is idle
    a_pend_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sbtr_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("square held back while idle");

    // pixel step stays inside the glyph
    a_pix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sbtr_pkg::ST_SCAN) |-> (pix_reg <= sbtr_pkg::LAST_PIX)
            && (col_reg <= sbtr_pkg::LAST_COL))
        else $error("glyph pixel index out of range");

    // every square leaving the block lies on the panel
    a_out_on_panel: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (LIM_W'(out_x_reg) + LIM_W'(out_size_reg) <= LIM_W'(PANEL_WIDTH))
            && (LIM_W'(out_y_reg) + LIM_W'(out_size_reg) <= LIM_W'(PANEL_HEIGHT)))
        else $error("square crosses the panel edge");

    // the closing square of a character goes out only from the flush step
    a_last_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && state_reg == sbtr_pkg::ST_FLUSH && out_free)
            |=> (out_valid_reg && out_last_reg && state_reg == sbtr_pkg::ST_IDLE))
        else $error("closing square lost");
`endif

endmodule

FILE: test/square_cmd_checker.sv
// square command checker: predicts the fill commands of each character word and compares them
`timescale 1ns / 1ps

module square_cmd_checker #(
    parameter int unsigned PANEL_WIDTH  = sbtr_pkg::PANEL_WIDTH_DEF,
    parameter int unsigned PANEL_HEIGHT = sbtr_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sbtr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sbtr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             squares_pending
);

    typedef struct {
        logic [9:0]  xpos;
        logic [9:0]  ypos;
        logic [7:0]  side;
        logic [15:0] ink;
        logic        tail;
    } square_t;

    square_t     squares_due[$];
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [7:0]  chars_drawn;
    logic [7:0]  chars_allowed;
    logic        text_closed;
    int          errs = 0;

    // rows top to bottom, three bits a row, left column in the top bit of each row
    function automatic logic [14:0] glyph_bits(input logic [7:0] code_in);
        logic [7:0] c;
        c = code_in;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h20;
        end
        case (c)
            8'h30: return 15'o75557;  8'h31: return 15'o26227;  8'h32: return 15'o71747;
            8'h33: return 15'o71717;  8'h34: return 15'o55711;  8'h35: return 15'o74717;
            8'h36: return 15'o74757;  8'h37: return 15'o71122;  8'h38: return 15'o75757;
            8'h39: return 15'o75717;
            8'h41: return 15'o25755;  8'h42: return 15'o65656;  8'h43: return 15'o34443;
            8'h44: return 15'o65556;  8'h45: return 15'o74647;  8'h46: return 15'o74644;
            8'h47: return 15'o34553;  8'h48: return 15'o55755;  8'h49: return 15'o72227;
            8'h4A: return 15'o11152;  8'h4B: return 15'o55655;  8'h4C: return 15'o44447;
            8'h4D: return 15'o57755;  8'h4E: return 15'o57775;  8'h4F: return 15'o25552;
            8'h50: return 15'o65644;  8'h51: return 15'o25531;  8'h52: return 15'o65655;
            8'h53: return 15'o34216;  8'h54: return 15'o72222;  8'h55: return 15'o55557;
            8'h56: return 15'o55552;  8'h57: return 15'o55775;  8'h58: return 15'o55255;
            8'h59: return 15'o55222;  8'h5A: return 15'o71247;
            8'h2D: return 15'o00700;  8'h3A: return 15'o02020;  8'h2E: return 15'o00002;
            8'h2F: return 15'o11244;  8'h5F: return 15'o00007;  8'h3F: return 15'o61202;
            8'h2B: return 15'o02720;  8'h3D: return 15'o07070;  8'h2A: return 15'o05250;
            8'h21: return 15'o22202;  8'h40: return 15'o75743;  8'h23: return 15'o57575;
            8'h24: return 15'o36236;  8'h25: return 15'o51245;  8'h26: return 15'o25253;
            8'h28: return 15'o12221;  8'h29: return 15'o42224;  8'h5B: return 15'o32223;
            8'h5D: return 15'o62226;  8'h27: return 15'o22000;  8'h2C: return 15'o00024;
            8'h3B: return 15'o02024;  8'h22: return 15'o55000;  8'h5C: return 15'o44211;
            8'h3C: return 15'o12421;  8'h3E: return 15'o42124;  8'h5E: return 15'o25000;
            8'h60: return 15'o21000;  8'h7B: return 15'o12621;  8'h7D: return 15'o42324;
            8'h7C: return 15'o22222;  8'h7E: return 15'o03600;
            default: return 15'o00000;
        endcase
    endfunction

    // expected squares of one accepted character word
    task automatic render_char(input logic begin_text, input logic [71:0] w);
        logic [7:0]  code;
        logic [15:0] ink;
        logic [7:0]  side;
        logic [14:0] glyph;
        logic [2:0]  line;
        int unsigned px;
        int unsigned py;
        square_t     hits[15];
        int          n;
        int          r;
        int          c;
        code = w[47:40];
        ink  = w[63:48];
        side = w[71:64];
        n    = 0;
        if (begin_text) begin
            pen_x         = w[15:0];
            pen_y         = w[31:16];
            chars_allowed = w[39:32];
            chars_drawn   = 8'd0;
            text_closed   = 1'b0;
        end
        if (text_closed) return;
        if (code == sbtr_pkg::CODE_NUL || chars_drawn >= chars_allowed) begin
            text_closed = 1'b1;
            return;
        end
        glyph = glyph_bits(code);
        for (r = 0; r < 5; r++) begin
            line = glyph[(4 - r) * 3 +: 3];
            for (c = 0; c < 3; c++) begin
                if (line[2 - c]) begin
                    px = (pen_x + c * side) & 32'hFFFF;
                    py = (pen_y + r * side) & 32'hFFFF;
                    // squares reaching past the panel edge are dropped
                    if (side != 0 && px + side <= PANEL_WIDTH && py + side <= PANEL_HEIGHT) begin
                        hits[n] = '{xpos: 10'(px), ypos: 10'(py), side: side, ink: ink,
                                    tail: 1'b0};
                        n++;
                    end
                end
            end
        end
        if (n > 0) hits[n - 1].tail = 1'b1;
        for (r = 0; r < n; r++) squares_due.push_back(hits[r]);
        pen_x       = 16'(pen_x + 4 * side);
        chars_drawn = chars_drawn + 8'd1;
    endtask

    task automatic check_square();
        square_t want;
        square_t got;
        logic [3:0] pad;
        got = '{xpos: m_tdata[9:0], ypos: m_tdata[19:10], side: m_tdata[27:20],
                ink: m_tdata[43:28], tail: m_tlast};
        pad = m_tdata[47:44];
        if (squares_due.size() == 0) begin
            errs++;
            if (errs <= 10)
                $display("unexpected square: x=%0d y=%0d size=%0d colour=%h last=%b",
                         got.xpos, got.ypos, got.side, got.ink, got.tail);
            return;
        end
        want = squares_due.pop_front();
        if (got.xpos != want.xpos || got.ypos != want.ypos || got.side != want.side ||
            got.ink != want.ink || got.tail != want.tail || pad != 4'd0) begin
            errs++;
            if (errs <= 10)
                $display("square mismatch: expected x=%0d y=%0d size=%0d colour=%h last=%b,",
                         want.xpos, want.ypos, want.side, want.ink, want.tail,
                         " got x=%0d y=%0d size=%0d colour=%h last=%b pad=%h",
                         got.xpos, got.ypos, got.side, got.ink, got.tail, pad);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pen_x         = 16'd0;
            pen_y         = 16'd0;
            chars_drawn   = 8'd0;
            chars_allowed = 8'd0;
            text_closed   = 1'b1;
            squares_due.delete();
        end else begin
            if (m_tvalid && m_tready) check_square();
            if (s_tvalid && s_tready) render_char(s_tuser, s_tdata);
        end
        mismatch_count  <= errs;
        squares_pending <= squares_due.size();
    end

endmodule

FILE: test/tb_scaled_bitmap_text_renderer.sv
// testbench top for the scaled bitmap text renderer: stimulus, idling, pressure and verdict
`timescale 1ns / 1ps

module tb_scaled_bitmap_text_renderer;

    // slowest plausible run is well under this, even with every square stalled
    localparam int unsigned CYCLE_LIMIT     = 600000;
    // margin that covers a character still in flight
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sbtr_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sbtr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;

    int          mismatch_count;
    int          squares_pending;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    // idling odds in percent, changed per phase
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    // raised by the stimulus to ask the receiver for its one long hold-off
    bit          hold_req    = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    scaled_bitmap_text_renderer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    square_cmd_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .squares_pending (squares_pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request, counted here
    initial begin
        int unsigned held;
        bit          hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // one character word; entered and left at a falling edge
    task automatic send_char(input logic begin_text, input logic [15:0] sx,
                             input logic [15:0] sy, input logic [7:0] lim,
                             input logic [7:0] code, input logic [15:0] ink,
                             input logic [7:0] side);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            // idle gap with junk on the data lines
            s_tvalid = 1'b0;
            s_tdata  = sbtr_pkg::S_TDATA_W'({$urandom, $urandom, $urandom});
            s_tuser  = 1'($urandom);
            do @(negedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid = 1'b1;
        s_tuser  = begin_text;
        // start_x, start_y, char_limit, char_code, ink_color, scale from the lowest bit up
        s_tdata  = {side, ink, code, lim, sy, sx};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // mostly glyphs, some lowercase, some unknown bytes and the odd nul
    function automatic logic [7:0] pick_code();
        case ($urandom_range(19))
            0:       return sbtr_pkg::CODE_NUL;
            1, 2:    return 8'($urandom);
            3, 4, 5: return 8'($urandom_range(8'h61, 8'h7A));
            6:       return 8'($urandom_range(8'h7B, 8'h7E));
            default: return 8'($urandom_range(8'h21, 8'h5F));
        endcase
    endfunction

    // small scales keep most squares on the panel
    function automatic logic [7:0] pick_scale();
        case ($urandom_range(9))
            0:       return 8'($urandom_range(1, 255));
            1:       return 8'hFF;
            default: return 8'($urandom_range(1, 4));
        endcase
    endfunction

    // a start word carrying the first character, then a run of characters
    task automatic random_text();
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  lim;
        logic [7:0]  side;
        int unsigned nchars;
        int unsigned k;
        case ($urandom_range(9))
            0: begin
                ox = 16'($urandom);
                oy = 16'($urandom);
            end
            1: begin
                // cursor close to the 16-bit wrap
                ox = 16'hFFFF - 16'($urandom_range(15));
                oy = 16'($urandom_range(0, 156));
            end
            default: begin
                ox = 16'($urandom_range(0, 124));
                oy = 16'($urandom_range(0, 156));
            end
        endcase
        case ($urandom_range(9))
            0:       lim = 8'd0;
            1:       lim = 8'($urandom);
            default: lim = 8'($urandom_range(1, 8));
        endcase
        side   = pick_scale();
        nchars = $urandom_range(1, 9);
        send_char(1'b1, ox, oy, lim, pick_code(), 16'($urandom), side);
        for (k = 1; k < nchars; k++) begin
            if ($urandom_range(4) == 0) side = pick_scale();
            // start fields carry junk, they only matter on a start word
            send_char(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), pick_code(),
                      16'($urandom), side);
        end
        // stray words outside any well-formed text
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3))
                send_char(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 8'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        int unsigned k;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        // text is closed out of reset, so this one is dropped
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h41, 16'hFFFF, 8'd1);
        send_char(1'b1, 16'd0, 16'd0, 8'd255, 8'h38, 16'h0000, 8'd1);
        // lowercase folds to uppercase
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h61, 16'hFFFF, 8'd2);
        // unknown code: blank glyph, still counts and moves the cursor
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h80, 16'hA5A5, 8'd3);
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h7E, 16'h5A5A, 8'd1);
        // largest scale: every square off the panel
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h7B, 16'h1111, 8'hFF);
        // nul closes the text, next character dropped
        send_char(1'b0, 16'd0, 16'd0, 8'd0, sbtr_pkg::CODE_NUL, 16'h2222, 8'd1);
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h42, 16'h3333, 8'd1);
        // near the bottom right corner: partly clipped, then wholly off
        send_char(1'b1, 16'd120, 16'd150, 8'd3, 8'h23, 16'h1234, 8'd4);
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h57, 16'h4321, 8'd4);
        // column and row wrap through zero
        send_char(1'b1, 16'hFFFE, 16'hFFFF, 8'd2, 8'h7C, 16'hBEEF, 8'd2);
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h5F, 16'hCAFE, 8'd1);
        // limit reached: dropped and text closed
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h5A, 16'h0F0F, 8'd1);
        // zero limit draws nothing
        send_char(1'b1, 16'd8, 16'd8, 8'd0, 8'h31, 16'hF0F0, 8'd1);
        // start fields ignored without the start flag
        send_char(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h32, 16'hFFFF, 8'hFF);
        send_char(1'b1, 16'd0, 16'd0, 8'd255, 8'h30, 16'hFFFF, 8'hFF);
        send_char(1'b1, 16'hFFFF, 16'd0, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_char(1'b1, 16'd0, 16'd0, 8'd1, 8'h40, 16'h8001, 8'd1);
        send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h3F, 16'h7FFE, 8'd1);

        // random part, phase by phase
        idle_pct  = 0;
        stall_pct = 0;
        while (items_sent < 40) random_text();

        idle_pct  = 75;
        while (items_sent < 80) random_text();

        // long hold-off while words keep coming: the block fills and stalls its input
        idle_pct = 0;
        hold_req = 1'b1;
        send_char(1'b1, 16'd0, 16'd0, 8'd255, 8'h38, 16'($urandom), 8'd1);
        for (k = 0; k < 19; k++)
            send_char(1'b0, 16'd0, 16'd0, 8'd0, 8'h38, 16'($urandom), 8'd1);

        stall_pct = 75;
        while (items_sent < 120) random_text();

        idle_pct  = 33;
        stall_pct = 33;
        while (items_sent < 160) random_text();

        s_tvalid = 1'b0;
        stall_pct = 0;

        while (squares_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && squares_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
